// ----- src/tsc_pkg.sv -----
// shared types and constants of the thresholded strip centroid
package tsc_pkg;

  localparam int STRIPS       = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = 8;
  localparam int BINS         = 24;
  localparam int THRESH_BITS  = 15;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(30);

  // magnitude of a strip that passed a non-negative threshold
  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int IDX_W   = $clog2(STRIPS);
  localparam int TOTAL_W = MAG_W + IDX_W;
  localparam int WSUM_W  = MAG_W + $clog2(STRIPS * (STRIPS - 1) / 2);
  localparam int POS_W   = FRAC_BITS + IDX_W;
  localparam int BIN_W   = $clog2(BINS);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] amp_strip0;
    logic signed [SAMPLE_BITS-1:0] amp_strip1;
    logic signed [SAMPLE_BITS-1:0] amp_strip2;
    logic signed [SAMPLE_BITS-1:0] amp_strip3;
    logic signed [SAMPLE_BITS-1:0] amp_strip4;
    logic signed [SAMPLE_BITS-1:0] amp_strip5;
    logic signed [SAMPLE_BITS-1:0] amp_strip6;
    logic signed [SAMPLE_BITS-1:0] amp_strip7;
  } in_t;

  typedef struct packed {
    logic               hit_found;
    logic [POS_W-1:0]   centroid_pos;
    logic [BIN_W-1:0]   centroid_bin;
    logic [TOTAL_W-1:0] amp_total;
  } out_t;

endpackage

// ----- src/thresholded_strip_centroid.sv -----
// top level: thresholded centre of gravity over one axis of strips
//
// Takes one event of eight strip amplitudes per clock while the output is not
// held off and returns one result per event after a threshold stage, two adder
// stages for the total and the weighted sum, an operand stage, eleven stages
// of a pipelined restoring divider (one position quotient bit each, the five
// bin quotient bits alongside in the first five) and the output register. The
// eleven-bit position quotient sets that depth. A stall at the output freezes
// the whole pipeline, and the input then stalls with it. The threshold may only
// be written while no event is in flight.
module thresholded_strip_centroid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tsc_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tsc_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tsc_pkg::THRESH_BITS-1:0]    cfg_data_i
);

  localparam int STRIPS  = tsc_pkg::STRIPS;
  localparam int HALF    = STRIPS / 2;
  localparam int MAG_W   = tsc_pkg::MAG_W;
  localparam int TOTAL_W = tsc_pkg::TOTAL_W;
  localparam int WSUM_W  = tsc_pkg::WSUM_W;
  localparam int POS_W   = tsc_pkg::POS_W;
  localparam int BIN_W   = tsc_pkg::BIN_W;
  localparam int POS_RW  = WSUM_W + tsc_pkg::FRAC_BITS + 1;
  localparam int BIN_RW  = WSUM_W + 2 + BIN_W + 1;

  typedef struct packed {
    logic               hit;
    logic [TOTAL_W-1:0] total;
    logic [POS_RW-1:0]  prem;
    logic [POS_RW-1:0]  pdiv;
    logic [POS_W-1:0]   pquo;
    logic [BIN_RW-1:0]  brem;
    logic [BIN_RW-1:0]  bdiv;
    logic [BIN_W-1:0]   bquo;
  } div_t;

  logic                                    en;
  logic [tsc_pkg::THRESH_BITS-1:0]         thr_q;
  logic signed [tsc_pkg::SAMPLE_BITS-1:0]  amp [STRIPS];
  logic signed [tsc_pkg::SAMPLE_BITS-1:0]  thr_s;

  logic                v1_q, v2_q, v3_q;
  logic [MAG_W-1:0]    mag_d [STRIPS];
  logic [MAG_W-1:0]    mag_q [STRIPS];
  logic [TOTAL_W-1:0]  elo_d, ehi_d, elo_q, ehi_q;
  logic [WSUM_W-1:0]   wlo_d, whi_d, wlo_q, whi_q;
  logic [TOTAL_W-1:0]  e_q;
  logic [WSUM_W-1:0]   w_q;
  div_t                op_d;

  logic                dv_q [POS_W+1];
  div_t                div_q [POS_W+1];

  logic                out_valid_q;
  tsc_pkg::out_t       out_d, out_q;

  // a held result freezes every stage
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tsc_pkg::THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign amp[0] = in_data_i.amp_strip0;
  assign amp[1] = in_data_i.amp_strip1;
  assign amp[2] = in_data_i.amp_strip2;
  assign amp[3] = in_data_i.amp_strip3;
  assign amp[4] = in_data_i.amp_strip4;
  assign amp[5] = in_data_i.amp_strip5;
  assign amp[6] = in_data_i.amp_strip6;
  assign amp[7] = in_data_i.amp_strip7;

  assign thr_s = $signed({1'b0, thr_q});

  // threshold: a passing strip is positive, so its low bits are its magnitude
  always_comb begin
    for (int i = 0; i < STRIPS; i++) begin
      mag_d[i] = (amp[i] > thr_s) ? amp[i][MAG_W-1:0] : '0;
    end
  end

  // half sums, weights are constants
  always_comb begin
    elo_d = '0;
    ehi_d = '0;
    wlo_d = '0;
    whi_d = '0;
    for (int i = 0; i < HALF; i++) begin
      elo_d = elo_d + TOTAL_W'(mag_q[i]);
      wlo_d = wlo_d + WSUM_W'(mag_q[i]) * WSUM_W'(i);
    end
    for (int i = HALF; i < STRIPS; i++) begin
      ehi_d = ehi_d + TOTAL_W'(mag_q[i]);
      whi_d = whi_d + WSUM_W'(mag_q[i]) * WSUM_W'(i);
    end
  end

  // divider operands
  always_comb begin
    op_d.hit   = (e_q != '0);
    op_d.total = e_q;
    op_d.prem  = POS_RW'(w_q) << tsc_pkg::FRAC_BITS;
    op_d.pdiv  = POS_RW'(e_q);
    op_d.pquo  = '0;
    op_d.brem  = ((BIN_RW'(w_q) << 1) + BIN_RW'(e_q)) * BIN_RW'(tsc_pkg::BINS);
    op_d.bdiv  = BIN_RW'(e_q) * BIN_RW'(2 * STRIPS);
    op_d.bquo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      dv_q[0]  <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      dv_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q    <= mag_d;
      elo_q    <= elo_d;
      ehi_q    <= ehi_d;
      wlo_q    <= wlo_d;
      whi_q    <= whi_d;
      e_q      <= elo_q + ehi_q;
      w_q      <= wlo_q + whi_q;
      div_q[0] <= op_d;
    end
  end

  // one restoring step per stage, highest quotient bit first
  for (genvar s = 0; s < POS_W; s++) begin : g_div
    localparam int  PSH   = POS_W - 1 - s;
    localparam bit  BSTEP = (s < BIN_W);
    localparam int  BSH   = BSTEP ? (BIN_W - 1 - s) : 0;

    logic [POS_RW-1:0] ptry;
    logic [BIN_RW-1:0] btry;
    div_t              nxt;

    assign ptry = div_q[s].pdiv << PSH;
    assign btry = div_q[s].bdiv << BSH;

    always_comb begin
      nxt = div_q[s];
      if (div_q[s].prem >= ptry) begin
        nxt.prem      = div_q[s].prem - ptry;
        nxt.pquo[PSH] = 1'b1;
      end
      if (BSTEP && (div_q[s].brem >= btry)) begin
        nxt.brem      = div_q[s].brem - btry;
        nxt.bquo[BSH] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (en) begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[s+1] <= nxt;
      end
    end
  end

  // no hit: the divider ran on a zero divisor, so clear its quotients; on a hit, clamp the bin to the last one
  always_comb begin
    out_d.hit_found    = div_q[POS_W].hit;
    out_d.amp_total    = div_q[POS_W].total;
    out_d.centroid_pos = div_q[POS_W].hit ? div_q[POS_W].pquo : '0;
    if (!div_q[POS_W].hit) begin
      out_d.centroid_bin = '0;
    end else if (div_q[POS_W].bquo > BIN_W'(tsc_pkg::BINS - 1)) begin
      out_d.centroid_bin = BIN_W'(tsc_pkg::BINS - 1);
    end else begin
      out_d.centroid_bin = div_q[POS_W].bquo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[POS_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- src/tsc_checker.sv -----
// port checker for the thresholded strip centroid, bound to the top level
module tsc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input tsc_pkg::out_t                    out_data_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

  // no hit means all fields clear
  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit_found |->
      out_data_o.centroid_pos == '0 && out_data_o.centroid_bin == '0 &&
      out_data_o.amp_total == '0)
    else $error("fields not cleared without hit");

  // hit flag agrees with the total
  a_hit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hit_found == (out_data_o.amp_total != '0))
    else $error("hit flag disagrees with total");

  // position and bin within the strip range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.centroid_bin <= tsc_pkg::BIN_W'(tsc_pkg::BINS - 1) &&
      out_data_o.centroid_pos <=
        tsc_pkg::POS_W'((tsc_pkg::STRIPS - 1) << tsc_pkg::FRAC_BITS))
    else $error("centroid out of range");

  // with nothing held at the output the input is never stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output empty");

endmodule

bind thresholded_strip_centroid tsc_checker u_tsc_checker (.*);
